FILE: hw/rtl/depth_image_backprojection_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for depth image backprojection
// Wraps concurrent assertions so synthesis sees nothing.
// ----------------------------------------------------------------------------
`ifndef DEPTH_IMAGE_BACKPROJECTION_ASSERT_SVH
`define DEPTH_IMAGE_BACKPROJECTION_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define DIBP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define DIBP_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DIBP_ASSERT(name, clk, rst_n, prop, msg)
`define DIBP_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

FILE: hw/rtl/dibp_pkg.sv
// ----------------------------------------------------------------------------
// dibp_pkg
// Types and fixed-point constants for the depth pixel backprojection block.
// ----------------------------------------------------------------------------
package dibp_pkg;

  // field widths
  localparam int COORD_BITS = 12;
  localparam int DEPTH_BITS = 16;
  localparam int COEF_W     = 32;
  localparam int POINT_W    = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_CFG    = 6;

  // datapath widths: coordinate*depth, coefficient product, row sum
  localparam int WORK_W = COORD_BITS + DEPTH_BITS;
  localparam int PROD_W = COEF_W + WORK_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  // Q.16 to Q.8 rounding
  localparam int FRAC_SHIFT = 8;
  localparam int ROUND_BIAS = 128;

  localparam logic [POINT_W-1:0] POINT_MAX = 32'h7FFF_FFFF;
  localparam logic [POINT_W-1:0] POINT_MIN = 32'h8000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0_FIRST  = 3'd0,
    CFG_ROW0_SECOND = 3'd1,
    CFG_ROW1_FIRST  = 3'd2,
    CFG_ROW1_SECOND = 3'd3,
    CFG_ROW2_FIRST  = 3'd4,
    CFG_ROW2_SECOND = 3'd5
  } cfg_reg_e;

  typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_regs_t;

  // identity-like defaults
  localparam cfg_regs_t CFG_RESET = {
    64'h0000_0000_0001_0000,  // row2 second pair
    64'h0000_0000_0000_0000,  // row2 first pair
    64'h0000_0000_0000_0000,  // row1 second pair
    64'h0001_0000_0000_0000,  // row1 first pair
    64'h0000_0000_0000_0000,  // row0 second pair
    64'h0000_0000_0001_0000   // row0 first pair
  };

  // input beat
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [DEPTH_BITS-1:0] depth_value;
    logic                  keep_pixel;
  } pixel_t;

  // result beat
  typedef struct packed {
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic signed [POINT_W-1:0] point_z;
    logic [COORD_BITS-1:0]     out_col;
    logic [COORD_BITS-1:0]     out_row;
  } point_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [WORK_W-1:0]     col_depth;
    logic [WORK_W-1:0]     row_depth;
    logic [DEPTH_BITS-1:0] depth;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } work_t;

endpackage

FILE: hw/rtl/dibp_front.sv
// ----------------------------------------------------------------------------
// dibp_front
// Accepts pixels, drops masked ones, forms col*d and row*d for the back end.
// ----------------------------------------------------------------------------
module dibp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  dibp_pkg::pixel_t pixel_i,
  output logic            full,
  output logic            q_push_o,
  output dibp_pkg::work_t q_data_o,
  input  logic            q_full_i
);
  import dibp_pkg::*;

  logic  valid_q, valid_d;
  work_t work_q, work_d;
  logic  accept;

  // holding register drains into the queue whenever there is room
  assign q_push_o = valid_q && !q_full_i;
  assign full     = valid_q && q_full_i;
  assign accept   = push && !full;
  assign q_data_o = work_q;

  // classify and scale the incoming pixel
  always_comb begin
    work_d.col       = pixel_i.pixel_col;
    work_d.row       = pixel_i.pixel_row;
    work_d.depth     = pixel_i.depth_value;
    work_d.col_depth = WORK_W'(pixel_i.pixel_col) * WORK_W'(pixel_i.depth_value);
    work_d.row_depth = WORK_W'(pixel_i.pixel_row) * WORK_W'(pixel_i.depth_value);
    if (accept) begin
      valid_d = pixel_i.keep_pixel;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_q <= work_d;
    end
  end

`include "depth_image_backprojection_assert.svh"

  // a masked pixel leaves nothing behind
  `DIBP_ASSERT(a_mask_drops, clk_i, rst_ni, accept && !pixel_i.keep_pixel |=> !valid_q, "masked pixel kept")
  // the held beat cannot vanish while the queue is full
  `DIBP_ASSERT(a_hold_full, clk_i, rst_ni, valid_q && q_full_i |=> valid_q, "held pixel lost")
  // an accepted unmasked pixel is always captured
  `DIBP_ASSERT(a_keep_load, clk_i, rst_ni, accept && pixel_i.keep_pixel |=> valid_q, "pixel not captured")

endmodule

FILE: hw/rtl/dibp_fifo.sv
// ----------------------------------------------------------------------------
// dibp_fifo
// Short queue between front and back ends.
// ----------------------------------------------------------------------------
module dibp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dibp_pkg::work_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output dibp_pkg::work_t data_o,
  output logic            empty_o
);
  import dibp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  work_t            entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

`include "depth_image_backprojection_assert.svh"

  // fill count never runs past the depth
  `DIBP_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > FULL_CNT, "queue overfilled")
  // fill count rises by one on a push without a pop
  `DIBP_ASSERT(a_count_step, clk_i, rst_ni, do_push && !do_pop |=> count_q == $past(count_q) + 1'b1, "count slip")
  // pointers agree whenever queue is empty
  `DIBP_ASSERT(a_ptr_empty, clk_i, rst_ni, empty_o |-> rd_ptr_q == wr_ptr_q, "pointer mismatch")

endmodule

FILE: hw/rtl/dibp_back.sv
// ----------------------------------------------------------------------------
// dibp_back
// Matrix rows times (col*d, row*d, d, 1), round to Q.8, saturate.
// ----------------------------------------------------------------------------
module dibp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dibp_pkg::cfg_regs_t cfg_i,
  input  logic                q_empty_i,
  input  dibp_pkg::work_t     q_data_i,
  output logic                q_pop_o,
  output logic                empty,
  input  logic                pop,
  output dibp_pkg::point_t    point_o
);
  import dibp_pkg::*;

  // stage 1: products
  logic                     s1_valid_q;
  logic signed [PROD_W-1:0] s1_prod_q [3][3];
  logic signed [COEF_W-1:0] s1_ofs_q  [3];
  logic [COORD_BITS-1:0]    s1_col_q, s1_row_q;
  // stage 2: pair sums
  logic                     s2_valid_q;
  logic signed [SUM_W-1:0]  s2_half_a_q [3];
  logic signed [SUM_W-1:0]  s2_half_b_q [3];
  logic [COORD_BITS-1:0]    s2_col_q, s2_row_q;
  // stage 3: row sums
  logic                     s3_valid_q;
  logic signed [SUM_W-1:0]  s3_sum_q [3];
  logic [COORD_BITS-1:0]    s3_col_q, s3_row_q;
  // stage 4: result
  logic                     s4_valid_q;
  point_t                   s4_point_q, s4_point_d;

  logic                     adv;
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [COEF_W-1:0] ofs_d  [3];
  logic [POINT_W-1:0]       res_d  [3];

  // whole pipe moves when the result slot frees up
  assign adv     = !s4_valid_q || pop;
  assign q_pop_o = !q_empty_i && adv;
  assign empty   = !s4_valid_q;
  assign point_o = s4_point_q;

  // coefficient products, one multiplier per term
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_d[r][0] = PROD_W'($signed(cfg_i[2*r][31:0])) *
                     PROD_W'($signed({1'b0, q_data_i.col_depth}));
      prod_d[r][1] = PROD_W'($signed(cfg_i[2*r][63:32])) *
                     PROD_W'($signed({1'b0, q_data_i.row_depth}));
      prod_d[r][2] = PROD_W'($signed(cfg_i[2*r+1][31:0])) *
                     PROD_W'($signed({1'b0, q_data_i.depth}));
      ofs_d[r]     = $signed(cfg_i[2*r+1][63:32]);
    end
  end

  // shift and clamp each row sum; the rounding bias is added with the pair sums
  always_comb begin
    logic signed [SUM_W-1:0] shr;
    logic [SUM_W-POINT_W:0]  top;
    shr = '0;
    top = '0;
    for (int r = 0; r < 3; r++) begin
      shr = s3_sum_q[r] >>> FRAC_SHIFT;
      top = shr[SUM_W-1:POINT_W-1];
      if ((&top) || !(|top)) begin
        res_d[r] = shr[POINT_W-1:0];
      end else if (shr[SUM_W-1]) begin
        res_d[r] = POINT_MIN;
      end else begin
        res_d[r] = POINT_MAX;
      end
    end
    s4_point_d.point_x = res_d[0];
    s4_point_d.point_y = res_d[1];
    s4_point_d.point_z = res_d[2];
    s4_point_d.out_col = s3_col_q;
    s4_point_d.out_row = s3_row_q;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= q_pop_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          s1_prod_q[r][k] <= prod_d[r][k];
        end
        s1_ofs_q[r]    <= ofs_d[r];
        s2_half_a_q[r] <= SUM_W'(s1_prod_q[r][0]) + SUM_W'(s1_prod_q[r][1]);
        s2_half_b_q[r] <= SUM_W'(s1_prod_q[r][2]) + SUM_W'(s1_ofs_q[r]) +
                          SUM_W'(ROUND_BIAS);
        s3_sum_q[r]    <= s2_half_a_q[r] + s2_half_b_q[r];
      end
      s1_col_q   <= q_data_i.col;
      s1_row_q   <= q_data_i.row;
      s2_col_q   <= s1_col_q;
      s2_row_q   <= s1_row_q;
      s3_col_q   <= s2_col_q;
      s3_row_q   <= s2_row_q;
      s4_point_q <= s4_point_d;
    end
  end

`include "depth_image_backprojection_assert.svh"

  // a beat in stage 1 reaches stage 2 when the pipe moves
  `DIBP_ASSERT(a_s1_moves, clk_i, rst_ni, s1_valid_q && adv |=> s2_valid_q, "stage 2 lost beat")
  // a waiting result is never overwritten
  `DIBP_ASSERT(a_res_hold, clk_i, rst_ni, s4_valid_q && !pop |=> s4_valid_q && $stable(s4_point_q), "result overwritten")
  // stage 3 beat lands in the result slot
  `DIBP_ASSERT(a_s3_moves, clk_i, rst_ni, s3_valid_q && adv |=> s4_valid_q, "result slot lost beat")

endmodule

FILE: hw/rtl/depth_image_backprojection.sv
// Path: an accepted pixel goes through the front holding register, the queue and
// back-end stages 1 to 4, and waits whenever the result or the queue waits on pop.
// Throughput: one pixel per cycle while the queue and the result port do not stall;
// masked pixels are accepted and produce nothing.
// Reset: matrix registers return to identity defaults, all queues empty.
// ----------------------------------------------------------------------------
// depth_image_backprojection
// Depth pixel to 3D point backprojection through a configured 3x4 matrix.
// ----------------------------------------------------------------------------
module depth_image_backprojection #(
  parameter int MID_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input
  input  logic                          push,
  input  dibp_pkg::pixel_t              pixel_i,
  output logic                          full,
  // point output
  output logic                          empty,
  input  logic                          pop,
  output dibp_pkg::point_t              point_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dibp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dibp_pkg::CFG_W-1:0]     cfg_data_i
);
  import dibp_pkg::*;

  cfg_regs_t cfg_q, cfg_d;
  logic      f_push, f_full, f_pop, f_empty;
  work_t     f_wdata, f_rdata;

  // matrix registers; writes to unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROW0_FIRST:  cfg_d[0] = cfg_data_i;
        CFG_ROW0_SECOND: cfg_d[1] = cfg_data_i;
        CFG_ROW1_FIRST:  cfg_d[2] = cfg_data_i;
        CFG_ROW1_SECOND: cfg_d[3] = cfg_data_i;
        CFG_ROW2_FIRST:  cfg_d[4] = cfg_data_i;
        CFG_ROW2_SECOND: cfg_d[5] = cfg_data_i;
        default:         cfg_d    = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end: accept and classify
  dibp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .pixel_i  (pixel_i),
    .full     (full),
    .q_push_o (f_push),
    .q_data_o (f_wdata),
    .q_full_i (f_full)
  );

  // decoupling queue
  dibp_fifo #(
    .DEPTH (MID_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_wdata),
    .full_o  (f_full),
    .pop_i   (f_pop),
    .data_o  (f_rdata),
    .empty_o (f_empty)
  );

  // back end: transform, round, saturate
  dibp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (f_empty),
    .q_data_i  (f_rdata),
    .q_pop_o   (f_pop),
    .empty     (empty),
    .pop       (pop),
    .point_o   (point_o)
  );

endmodule
